>>> src/pwmc_pkg.sv
// Package for the pulse width marker classifier: field widths, register
// indexes, reset values of the thresholds and the report class codes.
// No dependencies.
package pwmc_pkg;

  localparam int BYTE_WIDTH   = 8;
  localparam int THRESH_WIDTH = 16;
  localparam int FIELD_WIDTH  = 32;
  localparam int CLASS_WIDTH  = 2;
  localparam int REG_INDEX_WIDTH = 2;

  typedef logic [BYTE_WIDTH-1:0]      sample_byte_t;
  typedef logic [THRESH_WIDTH-1:0]    thresh_t;
  typedef logic [FIELD_WIDTH-1:0]     field_t;
  typedef logic [CLASS_WIDTH-1:0]     pulse_class_t;
  typedef logic [REG_INDEX_WIDTH-1:0] reg_index_t;

  // Configuration register indexes.
  localparam reg_index_t REG_SHORT_PULSE_MAX = 2'd0;
  localparam reg_index_t REG_TRIAL_PULSE_MAX = 2'd1;
  localparam reg_index_t REG_END_PULSE_MIN   = 2'd2;

  // Threshold values after reset.
  localparam thresh_t SHORT_PULSE_MAX_RESET = 16'd60;
  localparam thresh_t TRIAL_PULSE_MAX_RESET = 16'd100;
  localparam thresh_t END_PULSE_MIN_RESET   = 16'd150;

  // Report classes.
  localparam pulse_class_t CLASS_OTHER = 2'd0;
  localparam pulse_class_t CLASS_TRIAL = 2'd1;
  localparam pulse_class_t CLASS_END   = 2'd2;
  localparam pulse_class_t CLASS_NONE  = 2'd3;

  // Threshold set handed to the merging stage.
  typedef struct packed {
    thresh_t short_pulse_max;
    thresh_t trial_pulse_max;
    thresh_t end_pulse_min;
  } thresholds_t;

endpackage

>>> src/pwmc_if.sv
// Channel interfaces of the pulse width marker classifier: the sample
// channel and the report channel, each with valid/ready handshake.
// Depends on pwmc_pkg.
interface pwmc_in_if;
  import pwmc_pkg::*;

  logic         valid;
  logic         ready;
  sample_byte_t sample_byte;

  modport source (output valid, output sample_byte, input ready);
  modport sink (input valid, input sample_byte, output ready);
endinterface

interface pwmc_out_if;
  import pwmc_pkg::*;

  logic         valid;
  logic         ready;
  field_t       pulse_length;
  field_t       pulse_start;
  pulse_class_t pulse_class;
  field_t       high_total;
  field_t       trial_total;
  field_t       other_total;
  field_t       end_total;
  logic         last_in_byte;

  modport source (output valid, output pulse_length, output pulse_start,
                  output pulse_class, output high_total, output trial_total,
                  output other_total, output end_total, output last_in_byte,
                  input ready);
  modport sink (input valid, input pulse_length, input pulse_start,
                input pulse_class, input high_total, input trial_total,
                input other_total, input end_total, input last_in_byte,
                output ready);
endinterface

>>> src/pwmc_lane.sv
// One sample lane: the state of the stream just before its own sample,
// worked out from the carried counters and the samples below it.
// Depends on nothing but its parameters.
module pwmc_lane #(
  parameter int SAMPLES_PER_ITEM = 8,
  parameter int COUNT_WIDTH      = 32,
  parameter int LANE             = 0
) (
  input  logic [SAMPLES_PER_ITEM-1:0] samples,
  input  logic                        sample,
  input  logic [COUNT_WIDTH-1:0]      run_in,
  input  logic [COUNT_WIDTH-1:0]      idx_in,
  input  logic [COUNT_WIDTH-1:0]      high_in,
  output logic                        ends,
  output logic [COUNT_WIDTH-1:0]      length,
  output logic [COUNT_WIDTH-1:0]      index,
  output logic [COUNT_WIDTH-1:0]      high_total
);

  localparam int CntW = $clog2(SAMPLES_PER_ITEM + 1);
  localparam int SumW = COUNT_WIDTH + 1;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [CntW-1:0] lead;
  logic [CntW-1:0] pop;
  logic            broke;
  logic [SumW-1:0] run_sum;
  logic [SumW-1:0] idx_sum;
  logic [SumW-1:0] high_sum;

  // Count the highs directly below this lane (the open run) and all highs
  // below this lane.
  always_comb begin
    lead  = '0;
    pop   = '0;
    broke = 1'b0;
    for (int i = SAMPLES_PER_ITEM - 1; i >= 0; i--) begin
      if (i < LANE) begin
        if (!broke && samples[i]) begin
          lead = lead + CntW'(1);
        end else begin
          broke = 1'b1;
        end
        if (samples[i]) begin
          pop = pop + CntW'(1);
        end
      end
    end
  end

  assign run_sum  = {1'b0, run_in} + SumW'(LANE);
  assign idx_sum  = {1'b0, idx_in} + SumW'(LANE);
  assign high_sum = {1'b0, high_in} + SumW'(pop);

  // A run that reaches back to the start of the item continues the carried run.
  always_comb begin
    if (lead == CntW'(LANE)) begin
      length = run_sum[COUNT_WIDTH] ? CountMax : run_sum[COUNT_WIDTH-1:0];
    end else begin
      length = COUNT_WIDTH'(lead);
    end
  end

  assign index      = idx_sum[COUNT_WIDTH] ? CountMax : idx_sum[COUNT_WIDTH-1:0];
  assign high_total = high_sum[COUNT_WIDTH] ? CountMax : high_sum[COUNT_WIDTH-1:0];
  assign ends       = !sample && (length != '0);

endmodule

>>> src/pwmc_merge.sv
// Merging stage: holds the lane findings of one item and sends out the ended
// runs one report per beat, lowest lane first, classifying and counting them.
// Depends on pwmc_pkg and pwmc_out_if.
module pwmc_merge #(
  parameter int SAMPLES_PER_ITEM = 8,
  parameter int COUNT_WIDTH      = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          load,
  input  logic [SAMPLES_PER_ITEM-1:0]                   lane_ends,
  input  logic [SAMPLES_PER_ITEM-1:0][COUNT_WIDTH-1:0]  lane_len,
  input  logic [SAMPLES_PER_ITEM-1:0][COUNT_WIDTH-1:0]  lane_idx,
  input  logic [SAMPLES_PER_ITEM-1:0][COUNT_WIDTH-1:0]  lane_high,
  input  pwmc_pkg::thresholds_t                         thresholds,
  output logic                                          free,
  pwmc_out_if.source                                    reports
);
  import pwmc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [SAMPLES_PER_ITEM-1:0]                  pending;
  logic [SAMPLES_PER_ITEM-1:0]                  pending_next;
  logic [SAMPLES_PER_ITEM-1:0][COUNT_WIDTH-1:0] buf_len;
  logic [SAMPLES_PER_ITEM-1:0][COUNT_WIDTH-1:0] buf_idx;
  logic [SAMPLES_PER_ITEM-1:0][COUNT_WIDTH-1:0] buf_high;

  logic [SAMPLES_PER_ITEM-1:0] sel;
  logic [SAMPLES_PER_ITEM-1:0] rest;
  logic                        pop;
  logic                        last;
  logic [COUNT_WIDTH-1:0]      sel_len;
  logic [COUNT_WIDTH-1:0]      sel_idx;
  logic [COUNT_WIDTH-1:0]      sel_high;
  logic [COUNT_WIDTH-1:0]      sel_start;
  pulse_class_t                sel_class;

  logic [COUNT_WIDTH-1:0] trial_count;
  logic [COUNT_WIDTH-1:0] other_count;
  logic [COUNT_WIDTH-1:0] end_count;
  logic [COUNT_WIDTH-1:0] trial_count_next;
  logic [COUNT_WIDTH-1:0] other_count_next;
  logic [COUNT_WIDTH-1:0] end_count_next;

  // Lowest pending lane goes first.
  assign sel  = pending & (~pending + SAMPLES_PER_ITEM'(1));
  assign rest = pending & ~sel;
  assign last = (rest == '0);
  assign pop  = (pending != '0) && (!reports.valid || reports.ready);
  assign free = (pending == '0) || (pop && last);

  always_comb begin
    sel_len  = '0;
    sel_idx  = '0;
    sel_high = '0;
    for (int i = 0; i < SAMPLES_PER_ITEM; i++) begin
      if (sel[i]) begin
        sel_len  = sel_len | buf_len[i];
        sel_idx  = sel_idx | buf_idx[i];
        sel_high = sel_high | buf_high[i];
      end
    end
  end

  assign sel_start = (sel_idx >= sel_len) ? (sel_idx - sel_len) : '0;

  always_comb begin
    priority if (sel_len <= COUNT_WIDTH'(thresholds.short_pulse_max)) begin
      sel_class = CLASS_OTHER;
    end else if (sel_len <= COUNT_WIDTH'(thresholds.trial_pulse_max)) begin
      sel_class = CLASS_TRIAL;
    end else if (sel_len > COUNT_WIDTH'(thresholds.end_pulse_min)) begin
      sel_class = CLASS_END;
    end else begin
      sel_class = CLASS_NONE;
    end
  end

  always_comb begin
    other_count_next = other_count;
    trial_count_next = trial_count;
    end_count_next   = end_count;
    unique case (sel_class)
      CLASS_OTHER: begin
        if (other_count != CountMax) other_count_next = other_count + 1'b1;
      end
      CLASS_TRIAL: begin
        if (trial_count != CountMax) trial_count_next = trial_count + 1'b1;
      end
      CLASS_END: begin
        if (end_count != CountMax) end_count_next = end_count + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pending_next = pending;
    if (load) begin
      pending_next = lane_ends;
    end else if (pop) begin
      pending_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= '0;
      trial_count   <= '0;
      other_count   <= '0;
      end_count     <= '0;
      reports.valid <= 1'b0;
    end else begin
      pending <= pending_next;
      if (pop) begin
        trial_count   <= trial_count_next;
        other_count   <= other_count_next;
        end_count     <= end_count_next;
        reports.valid <= 1'b1;
      end else if (reports.ready) begin
        reports.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_len  <= lane_len;
      buf_idx  <= lane_idx;
      buf_high <= lane_high;
    end
    if (pop) begin
      reports.pulse_length <= FIELD_WIDTH'(sel_len);
      reports.pulse_start  <= FIELD_WIDTH'(sel_start);
      reports.pulse_class  <= sel_class;
      reports.high_total   <= FIELD_WIDTH'(sel_high);
      reports.trial_total  <= FIELD_WIDTH'(trial_count_next);
      reports.other_total  <= FIELD_WIDTH'(other_count_next);
      reports.end_total    <= FIELD_WIDTH'(end_count_next);
      reports.last_in_byte <= last;
    end
  end

endmodule

>>> src/pulse_width_marker_classifier.sv
// Pulse width marker classifier. Each beat on the sample channel carries
// SAMPLES_PER_ITEM one-bit samples, bit 0 first (bits above bit 7 of the byte
// read as low). Every run of high samples that a low sample ends produces one
// report beat with the run length, the index of its first sample, its class
// (other, trial, end or unclassified, decided by the three threshold registers
// in that priority order) and the saturating totals of high samples and of each
// class including that report. The last report caused by a sample beat is
// marked with last_in_byte; a run still open at the end of a beat carries over
// and is reported only once a later low sample ends it. A sample beat is taken
// when the merging stage is free; its reports follow at one per cycle while the
// report channel does not stall, and a new beat is taken once the last one's
// reports are sent. A beat ends at most (SAMPLES_PER_ITEM + 1) / 2 runs, four
// at eight samples per beat. All counters are COUNT_WIDTH bits wide and saturate;
// report fields are cut to 32 bits. Thresholds are to be written by the user
// through the cfg port only while the block is idle; the block does not enforce it.
module pulse_width_marker_classifier #(
  parameter int SAMPLES_PER_ITEM = 8,
  parameter int COUNT_WIDTH      = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  pwmc_pkg::reg_index_t cfg_index,
  input  pwmc_pkg::thresh_t    cfg_data,
  pwmc_in_if.sink              samples_in,
  pwmc_out_if.source           reports_out
);
  import pwmc_pkg::*;

  // Threshold registers.
  thresholds_t thresholds;

  // Stream state carried from one sample beat to the next.
  logic [COUNT_WIDTH-1:0] run_length;
  logic [COUNT_WIDTH-1:0] sample_index;
  logic [COUNT_WIDTH-1:0] high_seen;

  logic                                          accept;
  logic                                          merge_free;
  logic [SAMPLES_PER_ITEM-1:0]                   samples;
  logic [SAMPLES_PER_ITEM:0]                     lane_ends;
  logic [SAMPLES_PER_ITEM:0][COUNT_WIDTH-1:0]    lane_len;
  logic [SAMPLES_PER_ITEM:0][COUNT_WIDTH-1:0]    lane_idx;
  logic [SAMPLES_PER_ITEM:0][COUNT_WIDTH-1:0]    lane_high;

  assign samples_in.ready = merge_free;
  assign accept = samples_in.valid && samples_in.ready;

  // One lane per sample, plus one lane past the last sample whose view of
  // the stream is the state to carry into the next beat. Its end flag is
  // never used because it sees a low sample by construction.
  for (genvar j = 0; j <= SAMPLES_PER_ITEM; j++) begin : g_lane
    logic lane_bit;
    if (j < SAMPLES_PER_ITEM) begin : g_real
      if (j < BYTE_WIDTH) begin : g_byte
        assign samples[j] = samples_in.sample_byte[j];
      end else begin : g_pad
        assign samples[j] = 1'b0;
      end
      assign lane_bit = samples[j];
    end else begin : g_carry
      assign lane_bit = 1'b0;
    end

    pwmc_lane #(
      .SAMPLES_PER_ITEM(SAMPLES_PER_ITEM),
      .COUNT_WIDTH(COUNT_WIDTH),
      .LANE(j)
    ) u_lane (
      .samples(samples),
      .sample(lane_bit),
      .run_in(run_length),
      .idx_in(sample_index),
      .high_in(high_seen),
      .ends(lane_ends[j]),
      .length(lane_len[j]),
      .index(lane_idx[j]),
      .high_total(lane_high[j])
    );
  end

  // The merging stage buffers the findings of one beat and sends its reports.
  pwmc_merge #(
    .SAMPLES_PER_ITEM(SAMPLES_PER_ITEM),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_merge (
    .clk(clk),
    .rst(rst),
    .load(accept),
    .lane_ends(lane_ends[SAMPLES_PER_ITEM-1:0]),
    .lane_len(lane_len[SAMPLES_PER_ITEM-1:0]),
    .lane_idx(lane_idx[SAMPLES_PER_ITEM-1:0]),
    .lane_high(lane_high[SAMPLES_PER_ITEM-1:0]),
    .thresholds(thresholds),
    .free(merge_free),
    .reports(reports_out)
  );

  // Stream state advances by a whole beat when it is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_length   <= '0;
      sample_index <= '0;
      high_seen    <= '0;
    end else if (accept) begin
      run_length   <= lane_len[SAMPLES_PER_ITEM];
      sample_index <= lane_idx[SAMPLES_PER_ITEM];
      high_seen    <= lane_high[SAMPLES_PER_ITEM];
    end
  end

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      thresholds.short_pulse_max <= SHORT_PULSE_MAX_RESET;
      thresholds.trial_pulse_max <= TRIAL_PULSE_MAX_RESET;
      thresholds.end_pulse_min   <= END_PULSE_MIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SHORT_PULSE_MAX: thresholds.short_pulse_max <= cfg_data;
        REG_TRIAL_PULSE_MAX: thresholds.trial_pulse_max <= cfg_data;
        REG_END_PULSE_MIN:   thresholds.end_pulse_min   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule
